@@ sv/fmd_pkg.sv @@
// Shared constants, codes and controller/datapath link types for the frame deframer.
package fmd_pkg;

  // Largest payload a frame may carry
  localparam int unsigned MAX_PAYLOAD = 12;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Result status codes
  localparam logic [1:0] ST_GOOD      = 2'd0;
  localparam logic [1:0] ST_LEN_ERR   = 2'd1;
  localparam logic [1:0] ST_FRAME_ERR = 2'd2;

  // Message kind codes
  localparam logic [1:0] KIND_OTHER   = 2'd0;
  localparam logic [1:0] KIND_SERVICE = 2'd1;
  localparam logic [1:0] KIND_PROCESS = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_BASE = 3'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic cap_id_hi;
    logic cap_id_lo;
    logic cap_len;
    logic store_byte;
    logic start_drain;
    logic load_good;
    logic load_len_err;
    logic load_frame_err;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic start_match;
    logic len_ok;
    logic count_done;
    logic end_match;
    logic drain_last;
  } dp_status_t;

endpackage

@@ sv/framed_message_deframer.sv @@
// Top level of the framed message deframer: controller plus datapath.
//
//  channel  | signals                              | request moved when
//  ---------+--------------------------------------+---------------------------
//  input    | in_valid, in_stall, rx_byte          | in_valid && !in_stall
//  output   | out_valid, out_stall, status..last   | out_valid && !out_stall
//  config   | cfg_valid, cfg_ready, cfg_index/data | cfg_valid && cfg_ready
//
// A byte that yields no result is taken every cycle while the output register is free.
// A length or framing error puts one request into the output register; the
// input takes the next byte as soon as that register is free.
// A good frame of N data bytes drains from the payload buffer, one output
// request per cycle while the output is not stalled, with the input stalled until the drain ends.
// Output stall holds the result register and stalls the input behind it.
// Synchronous reset returns the parser to the start-byte hunt and clears the
// state, config and header registers; payload and result data are not cleared.
module framed_message_deframer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fmd_pkg::BYTE_W-1:0]      rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      status,
  output logic [1:0]                      msg_kind,
  output logic [fmd_pkg::ID_W-1:0]        frame_id,
  output logic [fmd_pkg::LEN_W-1:0]       frame_length,
  output logic [fmd_pkg::LEN_W-1:0]       byte_index,
  output logic [fmd_pkg::BYTE_W-1:0]      data_byte,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fmd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  fmd_pkg::dp_cmd_t    dp_cmd;
  fmd_pkg::dp_status_t dp_status;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  fmd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  fmd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (rx_byte),
    .dp_cmd       (dp_cmd),
    .dp_status    (dp_status),
    .status       (status),
    .msg_kind     (msg_kind),
    .frame_id     (frame_id),
    .frame_length (frame_length),
    .byte_index   (byte_index),
    .data_byte    (data_byte),
    .last         (last)
  );

endmodule

@@ sv/fmd_ctrl.sv @@
// Parse controller: frame phase sequencing, input stall and output valid.
module fmd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  fmd_pkg::dp_status_t dp_status,
  output fmd_pkg::dp_cmd_t    dp_cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ID_HI,
    S_ID_LO,
    S_LEN,
    S_DATA,
    S_EOF,
    S_DRAIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   take;
  logic   load_any;

  // Output register can take a new result this cycle
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state == S_DRAIN) || !out_free;
  assign take     = in_valid && !in_stall;

  // Decode datapath commands
  always_comb begin
    dp_cmd                = '0;
    dp_cmd.cap_id_hi      = take && (state == S_ID_HI);
    dp_cmd.cap_id_lo      = take && (state == S_ID_LO);
    dp_cmd.cap_len        = take && (state == S_LEN) && dp_status.len_ok;
    dp_cmd.load_len_err   = take && (state == S_LEN) && !dp_status.len_ok;
    dp_cmd.store_byte     = take && (state == S_DATA);
    dp_cmd.start_drain    = take && (state == S_EOF) && dp_status.end_match;
    dp_cmd.load_frame_err = take && (state == S_EOF) && !dp_status.end_match;
    dp_cmd.load_good      = (state == S_DRAIN) && out_free;
  end

  assign load_any = dp_cmd.load_good || dp_cmd.load_len_err || dp_cmd.load_frame_err;

  // Next phase
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take && dp_status.start_match) state_next = S_ID_HI;
      end
      S_ID_HI: begin
        if (take) state_next = S_ID_LO;
      end
      S_ID_LO: begin
        if (take) state_next = S_LEN;
      end
      S_LEN: begin
        if (take) state_next = dp_status.len_ok ? S_DATA : S_IDLE;
      end
      S_DATA: begin
        if (take && dp_status.count_done) state_next = S_EOF;
      end
      S_EOF: begin
        if (take) state_next = dp_status.end_match ? S_DRAIN : S_IDLE;
      end
      S_DRAIN: begin
        if (out_free && dp_status.drain_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold phase and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= load_any || (out_valid && out_stall);
    end
  end

endmodule

@@ sv/fmd_dp.sv @@
// Datapath: configuration registers, frame header holds, payload buffer and result register.
module fmd_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [fmd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fmd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [fmd_pkg::BYTE_W-1:0]           rx_byte,
  input  fmd_pkg::dp_cmd_t                     dp_cmd,
  output fmd_pkg::dp_status_t                  dp_status,
  output logic [1:0]                           status,
  output logic [1:0]                           msg_kind,
  output logic [fmd_pkg::ID_W-1:0]             frame_id,
  output logic [fmd_pkg::LEN_W-1:0]            frame_length,
  output logic [fmd_pkg::LEN_W-1:0]            byte_index,
  output logic [fmd_pkg::BYTE_W-1:0]           data_byte,
  output logic                                 last
);

  logic [fmd_pkg::BYTE_W-1:0] start_byte;
  logic [fmd_pkg::BYTE_W-1:0] end_byte;
  logic [fmd_pkg::ID_W-1:0]   node_id;
  logic [fmd_pkg::ID_W-1:0]   service_reply_base;
  logic [fmd_pkg::ID_W-1:0]   process_data_base;

  logic [fmd_pkg::ID_W-1:0]   id_hold;
  logic [fmd_pkg::LEN_W-1:0]  length_hold;
  logic [fmd_pkg::LEN_W-1:0]  byte_count;
  logic [fmd_pkg::LEN_W-1:0]  drain_idx;
  logic [1:0]                 kind_hold;
  logic [fmd_pkg::BYTE_W-1:0] payload_store [fmd_pkg::MAX_PAYLOAD];

  logic [fmd_pkg::ID_W:0]     id_diff;
  logic [1:0]                 kind_calc;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte         <= '0;
      end_byte           <= '0;
      node_id            <= '0;
      service_reply_base <= '0;
      process_data_base  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fmd_pkg::CFG_START_BYTE:   start_byte         <= cfg_data[fmd_pkg::BYTE_W-1:0];
        fmd_pkg::CFG_END_BYTE:     end_byte           <= cfg_data[fmd_pkg::BYTE_W-1:0];
        fmd_pkg::CFG_NODE_ID:      node_id            <= cfg_data;
        fmd_pkg::CFG_SERVICE_BASE: service_reply_base <= cfg_data;
        fmd_pkg::CFG_PROCESS_BASE: process_data_base  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify identifier relative to the node number; borrow means below node
  assign id_diff = {1'b0, id_hold} - {1'b0, node_id};
  always_comb begin
    priority if (id_diff[fmd_pkg::ID_W]) begin
      kind_calc = fmd_pkg::KIND_OTHER;
    end else if (id_diff[fmd_pkg::ID_W-1:0] == service_reply_base) begin
      kind_calc = fmd_pkg::KIND_SERVICE;
    end else if (id_diff[fmd_pkg::ID_W-1:0] == process_data_base) begin
      kind_calc = fmd_pkg::KIND_PROCESS;
    end else begin
      kind_calc = fmd_pkg::KIND_OTHER;
    end
  end

  // Status toward the controller
  always_comb begin
    dp_status.start_match = (rx_byte == start_byte);
    dp_status.len_ok      = (rx_byte != '0) &&
                            (rx_byte <= fmd_pkg::BYTE_W'(fmd_pkg::MAX_PAYLOAD));
    dp_status.count_done  = ({1'b0, byte_count} + (fmd_pkg::LEN_W+1)'(1)) >=
                            {1'b0, length_hold};
    dp_status.end_match   = (rx_byte == end_byte);
    dp_status.drain_last  = ({1'b0, drain_idx} + (fmd_pkg::LEN_W+1)'(1)) ==
                            {1'b0, length_hold};
  end

  // Capture header fields and count data bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      id_hold     <= '0;
      length_hold <= '0;
      byte_count  <= '0;
      drain_idx   <= '0;
      kind_hold   <= fmd_pkg::KIND_OTHER;
    end else begin
      if (dp_cmd.cap_id_hi) begin
        id_hold <= {rx_byte, fmd_pkg::BYTE_W'(0)};
      end
      if (dp_cmd.cap_id_lo) begin
        id_hold <= {id_hold[fmd_pkg::ID_W-1:fmd_pkg::BYTE_W], rx_byte};
      end
      if (dp_cmd.cap_len) begin
        length_hold <= rx_byte[fmd_pkg::LEN_W-1:0];
        byte_count  <= '0;
      end
      if (dp_cmd.store_byte) begin
        byte_count <= byte_count + fmd_pkg::LEN_W'(1);
      end
      if (dp_cmd.start_drain) begin
        kind_hold <= kind_calc;
        drain_idx <= '0;
      end
      if (dp_cmd.load_good) begin
        drain_idx <= drain_idx + fmd_pkg::LEN_W'(1);
      end
    end
  end

  // Payload buffer write
  always_ff @(posedge clk) begin
    if (dp_cmd.store_byte) begin
      payload_store[byte_count] <= rx_byte;
    end
  end

  // Result register; good bytes read the buffer here
  always_ff @(posedge clk) begin
    if (dp_cmd.load_good) begin
      status       <= fmd_pkg::ST_GOOD;
      msg_kind     <= kind_hold;
      frame_id     <= id_hold;
      frame_length <= length_hold;
      byte_index   <= drain_idx;
      data_byte    <= payload_store[drain_idx];
      last         <= dp_status.drain_last;
    end else if (dp_cmd.load_len_err) begin
      status       <= fmd_pkg::ST_LEN_ERR;
      msg_kind     <= fmd_pkg::KIND_OTHER;
      frame_id     <= id_hold;
      frame_length <= '0;
      byte_index   <= '0;
      data_byte    <= rx_byte;
      last         <= 1'b1;
    end else if (dp_cmd.load_frame_err) begin
      status       <= fmd_pkg::ST_FRAME_ERR;
      msg_kind     <= fmd_pkg::KIND_OTHER;
      frame_id     <= id_hold;
      frame_length <= length_hold;
      byte_index   <= '0;
      data_byte    <= rx_byte;
      last         <= 1'b1;
    end
  end

endmodule

@@ sv/fmd_checker.sv @@
// Port-level checker for the framed message deframer and its bind.
module fmd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [1:0]                      status,
  input logic [1:0]                      msg_kind,
  input logic [fmd_pkg::LEN_W-1:0]       frame_length,
  input logic [fmd_pkg::LEN_W-1:0]       byte_index,
  input logic [fmd_pkg::BYTE_W-1:0]      data_byte,
  input logic                            last
);

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(byte_index))
    else $error("stalled result changed");

  // Error results are single and carry no kind
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != fmd_pkg::ST_GOOD) |-> last && (msg_kind == fmd_pkg::KIND_OTHER))
    else $error("error result not last or has a kind");

  // Length error reports zero length
  a_len_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == fmd_pkg::ST_LEN_ERR) |-> (frame_length == '0) &&
    (byte_index == '0))
    else $error("length error fields wrong");

  // Good byte index lies inside the frame, last marks the final one
  a_good_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == fmd_pkg::ST_GOOD) |->
    (byte_index < frame_length) &&
    (last == (({1'b0, byte_index} + 5'd1) == {1'b0, frame_length})))
    else $error("good result index or last wrong");

endmodule

bind framed_message_deframer fmd_checker u_fmd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .msg_kind     (msg_kind),
  .frame_length (frame_length),
  .byte_index   (byte_index),
  .data_byte    (data_byte),
  .last         (last)
);
